### hw/rtl/rlstd_pkg.sv
// ----------------------------------------------------------------------------
// rlstd_pkg
// Shared types, status codes and opcode match values for the trapped
// load/store decoder.
// ----------------------------------------------------------------------------
package rlstd_pkg;

    localparam int XLEN_DEF  = 64;

    localparam int S_TDATA_W = 264;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 208;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FETCH_FAULT = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_ACCESS_ERR  = 2'd3
    } t_status;

    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_B    = 4'd1;
    localparam logic [3:0] LEN_H    = 4'd2;
    localparam logic [3:0] LEN_W    = 4'd4;
    localparam logic [3:0] LEN_D    = 4'd8;

    localparam logic [2:0] ILEN_C   = 3'd2;
    localparam logic [2:0] ILEN_I   = 3'd4;

    localparam logic [15:0] MASK_I  = 16'h707f;
    localparam logic [15:0] MASK_C  = 16'he003;

    localparam logic [15:0] OP_LB    = 16'h0003;
    localparam logic [15:0] OP_LH    = 16'h1003;
    localparam logic [15:0] OP_LW    = 16'h2003;
    localparam logic [15:0] OP_LD    = 16'h3003;
    localparam logic [15:0] OP_LBU   = 16'h4003;
    localparam logic [15:0] OP_LHU   = 16'h5003;
    localparam logic [15:0] OP_LWU   = 16'h6003;
    localparam logic [15:0] OP_SB    = 16'h0023;
    localparam logic [15:0] OP_SH    = 16'h1023;
    localparam logic [15:0] OP_SW    = 16'h2023;
    localparam logic [15:0] OP_SD    = 16'h3023;
    localparam logic [15:0] OP_CLW   = 16'h4000;
    localparam logic [15:0] OP_CLD   = 16'h6000;
    localparam logic [15:0] OP_CLWSP = 16'h4002;
    localparam logic [15:0] OP_CLDSP = 16'h6002;
    localparam logic [15:0] OP_CSW   = 16'hc000;
    localparam logic [15:0] OP_CSD   = 16'he000;
    localparam logic [15:0] OP_CSWSP = 16'hc002;
    localparam logic [15:0] OP_CSDSP = 16'he002;

    typedef struct packed {
        t_status     status;
        logic [3:0]  access_len;
        logic        sgn;
        logic [4:0]  reg_index;
        logic        is_store;
        logic [2:0]  inst_len;
    } t_ctl;

endpackage

### hw/rtl/rlstd_decode.sv
// ----------------------------------------------------------------------------
// rlstd_decode
// First stage: select the instruction word, decode the load or store form
// and resolve the status.
// ----------------------------------------------------------------------------
module rlstd_decode #(
    parameter int XLEN = rlstd_pkg::XLEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [31:0]       i_trap_inst,
    input  logic [31:0]       i_fetched_inst,
    input  logic              i_fetch_fault,
    input  logic [63:0]       i_fault_pc,
    input  logic [63:0]       i_access_address,
    input  logic [63:0]       i_load_data,
    input  logic              i_access_error,
    output logic              o_valid,
    input  logic              i_ready,
    output rlstd_pkg::t_ctl   o_ctl,
    output logic [XLEN-1:0]   o_pc,
    output logic [XLEN-1:0]   o_addr,
    output logic [XLEN-1:0]   o_data
);

    localparam bit Rv64Forms = (XLEN >= 64);

    logic              r_valid;
    rlstd_pkg::t_ctl   r_ctl;
    rlstd_pkg::t_ctl   n_ctl;
    logic [XLEN-1:0]   r_pc;
    logic [XLEN-1:0]   r_addr;
    logic [XLEN-1:0]   r_data;

    logic [31:0]       w;
    logic [15:0]       f32;
    logic [15:0]       f16;
    logic [4:0]        rd;
    logic [4:0]        rs2;
    logic [4:0]        rs2s;
    logic [4:0]        rs2c;
    logic              ffault;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_ctl = '0;
        if (i_trap_inst[0]) begin
            w              = i_trap_inst | 32'h3;
            n_ctl.inst_len = i_trap_inst[1] ? rlstd_pkg::ILEN_I : rlstd_pkg::ILEN_C;
        end else begin
            w              = i_fetched_inst;
            n_ctl.inst_len = (i_fetched_inst[1:0] == 2'b11) ? rlstd_pkg::ILEN_I
                                                            : rlstd_pkg::ILEN_C;
        end
        ffault = !i_trap_inst[0] && i_fetch_fault;
        f32    = w[15:0] & rlstd_pkg::MASK_I;
        f16    = w[15:0] & rlstd_pkg::MASK_C;
        rd     = w[11:7];
        rs2    = w[24:20];
        rs2s   = {2'b01, w[4:2]};
        rs2c   = w[6:2];
        n_ctl.is_store = i_command;

        if (!i_command) begin
            unique case (f32)
                rlstd_pkg::OP_LW: begin
                    n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.sgn = 1'b1; n_ctl.reg_index = rd;
                end
                rlstd_pkg::OP_LD: begin
                    if (Rv64Forms) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.sgn = 1'b1;
                        n_ctl.reg_index = rd;
                    end
                end
                rlstd_pkg::OP_LWU: begin
                    if (Rv64Forms) begin
                        n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.reg_index = rd;
                    end
                end
                rlstd_pkg::OP_LH: begin
                    n_ctl.access_len = rlstd_pkg::LEN_H; n_ctl.sgn = 1'b1; n_ctl.reg_index = rd;
                end
                rlstd_pkg::OP_LHU: begin
                    n_ctl.access_len = rlstd_pkg::LEN_H; n_ctl.reg_index = rd;
                end
                rlstd_pkg::OP_LB: begin
                    n_ctl.access_len = rlstd_pkg::LEN_B; n_ctl.sgn = 1'b1; n_ctl.reg_index = rd;
                end
                rlstd_pkg::OP_LBU: begin
                    n_ctl.access_len = rlstd_pkg::LEN_B; n_ctl.reg_index = rd;
                end
                default: ;
            endcase
            unique case (f16)
                rlstd_pkg::OP_CLD: begin
                    if (Rv64Forms) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.sgn = 1'b1;
                        n_ctl.reg_index = rs2s;
                    end
                end
                rlstd_pkg::OP_CLDSP: begin
                    if (Rv64Forms && rd != 5'd0) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.sgn = 1'b1;
                        n_ctl.reg_index = rd;
                    end
                end
                rlstd_pkg::OP_CLW: begin
                    n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.sgn = 1'b1;
                    n_ctl.reg_index = rs2s;
                end
                rlstd_pkg::OP_CLWSP: begin
                    if (rd != 5'd0) begin
                        n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.sgn = 1'b1;
                        n_ctl.reg_index = rd;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (f32)
                rlstd_pkg::OP_SW: begin
                    n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.reg_index = rs2;
                end
                rlstd_pkg::OP_SD: begin
                    if (Rv64Forms) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.reg_index = rs2;
                    end
                end
                rlstd_pkg::OP_SH: begin
                    n_ctl.access_len = rlstd_pkg::LEN_H; n_ctl.reg_index = rs2;
                end
                rlstd_pkg::OP_SB: begin
                    n_ctl.access_len = rlstd_pkg::LEN_B; n_ctl.reg_index = rs2;
                end
                default: ;
            endcase
            unique case (f16)
                rlstd_pkg::OP_CSD: begin
                    if (Rv64Forms) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.reg_index = rs2s;
                    end
                end
                rlstd_pkg::OP_CSDSP: begin
                    if (Rv64Forms && rd != 5'd0) begin
                        n_ctl.access_len = rlstd_pkg::LEN_D; n_ctl.reg_index = rs2c;
                    end
                end
                rlstd_pkg::OP_CSW: begin
                    n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.reg_index = rs2s;
                end
                rlstd_pkg::OP_CSWSP: begin
                    if (rd != 5'd0) begin
                        n_ctl.access_len = rlstd_pkg::LEN_W; n_ctl.reg_index = rs2c;
                    end
                end
                default: ;
            endcase
        end

        if (ffault) begin
            n_ctl.status     = rlstd_pkg::ST_FETCH_FAULT;
            n_ctl.inst_len   = rlstd_pkg::ILEN_I;
            n_ctl.access_len = rlstd_pkg::LEN_NONE;
            n_ctl.reg_index  = 5'd0;
        end else if (n_ctl.access_len == rlstd_pkg::LEN_NONE) begin
            n_ctl.status     = rlstd_pkg::ST_UNSUPPORTED;
            n_ctl.reg_index  = 5'd0;
        end else if (i_access_error) begin
            n_ctl.status     = rlstd_pkg::ST_ACCESS_ERR;
        end else begin
            n_ctl.status     = rlstd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl  <= n_ctl;
            r_pc   <= i_fault_pc[XLEN-1:0];
            r_addr <= i_access_address[XLEN-1:0];
            r_data <= i_load_data[XLEN-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_pc    = r_pc;
    assign o_addr  = r_addr;
    assign o_data  = r_data;

endmodule

### hw/rtl/rlstd_extend.sv
// ----------------------------------------------------------------------------
// rlstd_extend
// Second stage: sign or zero extend the load bytes and form the next pc.
// ----------------------------------------------------------------------------
module rlstd_extend #(
    parameter int XLEN = rlstd_pkg::XLEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rlstd_pkg::t_ctl   i_ctl,
    input  logic [XLEN-1:0]   i_pc,
    input  logic [XLEN-1:0]   i_addr,
    input  logic [XLEN-1:0]   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rlstd_pkg::t_ctl   o_ctl,
    output logic [XLEN-1:0]   o_pc,
    output logic [XLEN-1:0]   o_pc_next,
    output logic [XLEN-1:0]   o_addr,
    output logic [XLEN-1:0]   o_ext
);

    logic              r_valid;
    rlstd_pkg::t_ctl   r_ctl;
    logic [XLEN-1:0]   r_pc;
    logic [XLEN-1:0]   r_pc_next;
    logic [XLEN-1:0]   r_addr;
    logic [XLEN-1:0]   r_ext;
    logic [XLEN-1:0]   n_ext;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        case (i_ctl.access_len)
            rlstd_pkg::LEN_B: n_ext = i_ctl.sgn ? XLEN'($signed(i_data[7:0]))
                                                : XLEN'(i_data[7:0]);
            rlstd_pkg::LEN_H: n_ext = i_ctl.sgn ? XLEN'($signed(i_data[15:0]))
                                                : XLEN'(i_data[15:0]);
            rlstd_pkg::LEN_W: n_ext = i_ctl.sgn ? XLEN'($signed(i_data[31:0]))
                                                : XLEN'(i_data[31:0]);
            default:          n_ext = i_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl     <= i_ctl;
            r_pc      <= i_pc;
            r_pc_next <= i_pc + XLEN'(i_ctl.inst_len);
            r_addr    <= i_addr;
            r_ext     <= n_ext;
        end
    end

    assign o_valid   = r_valid;
    assign o_ctl     = r_ctl;
    assign o_pc      = r_pc;
    assign o_pc_next = r_pc_next;
    assign o_addr    = r_addr;
    assign o_ext     = r_ext;

endmodule

### hw/rtl/rlstd_result.sv
// ----------------------------------------------------------------------------
// rlstd_result
// Third stage: gate the result fields by status and hold the output request.
// ----------------------------------------------------------------------------
module rlstd_result #(
    parameter int XLEN = rlstd_pkg::XLEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rlstd_pkg::t_ctl     i_ctl,
    input  logic [XLEN-1:0]     i_pc,
    input  logic [XLEN-1:0]     i_pc_next,
    input  logic [XLEN-1:0]     i_addr,
    input  logic [XLEN-1:0]     i_ext,
    output logic                o_valid,
    input  logic                i_ready,
    output rlstd_pkg::t_status  o_status,
    output logic [3:0]          o_access_len,
    output logic [XLEN-1:0]     o_address_out,
    output logic [4:0]          o_reg_index,
    output logic                o_reg_write,
    output logic [XLEN-1:0]     o_write_value,
    output logic [XLEN-1:0]     o_next_pc,
    output logic [2:0]          o_inst_len
);

    logic                r_valid;
    rlstd_pkg::t_status  r_status;
    logic [3:0]          r_access_len;
    logic [XLEN-1:0]     r_address_out;
    logic [4:0]          r_reg_index;
    logic                r_reg_write;
    logic [XLEN-1:0]     r_write_value;
    logic [XLEN-1:0]     r_next_pc;
    logic [2:0]          r_inst_len;

    logic                ok;
    logic                decoded;
    logic                n_reg_write;

    assign o_ready     = !r_valid || i_ready;
    assign ok          = (i_ctl.status == rlstd_pkg::ST_OK);
    assign decoded     = (i_ctl.access_len != rlstd_pkg::LEN_NONE);
    assign n_reg_write = ok && !i_ctl.is_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_status      <= i_ctl.status;
            r_access_len  <= i_ctl.access_len;
            r_address_out <= decoded ? i_addr : '0;
            r_reg_index   <= i_ctl.reg_index;
            r_reg_write   <= n_reg_write;
            r_write_value <= n_reg_write ? i_ext : '0;
            r_next_pc     <= ok ? i_pc_next : i_pc;
            r_inst_len    <= i_ctl.inst_len;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_access_len  = r_access_len;
    assign o_address_out = r_address_out;
    assign o_reg_index   = r_reg_index;
    assign o_reg_write   = r_reg_write;
    assign o_write_value = r_write_value;
    assign o_next_pc     = r_next_pc;
    assign o_inst_len    = r_inst_len;

endmodule

### hw/rtl/riscv_load_store_trap_decoder.sv
// ----------------------------------------------------------------------------
// riscv_load_store_trap_decoder
// Stages: decode, extend and result register, in order from input to output.
// Throughput: one request per cycle unless the output side stalls;
//   each stage advances independently.
// Reset: synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module riscv_load_store_trap_decoder #(
    parameter int XLEN = rlstd_pkg::XLEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // trap_inst, fetched_inst, fetch_fault, fault_pc, access_address,
    // load_data, access_error, zero pad
    input  logic [rlstd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  logic [rlstd_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // access_len, address_out, reg_index, reg_write, write_value, next_pc,
    // inst_len, zero pad
    output logic [rlstd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [rlstd_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    logic                s1_valid;
    logic                s1_ready;
    rlstd_pkg::t_ctl     s1_ctl;
    logic [XLEN-1:0]     s1_pc;
    logic [XLEN-1:0]     s1_addr;
    logic [XLEN-1:0]     s1_data;

    logic                s2_valid;
    logic                s2_ready;
    rlstd_pkg::t_ctl     s2_ctl;
    logic [XLEN-1:0]     s2_pc;
    logic [XLEN-1:0]     s2_pc_next;
    logic [XLEN-1:0]     s2_addr;
    logic [XLEN-1:0]     s2_ext;

    rlstd_pkg::t_status  res_status;
    logic [3:0]          res_access_len;
    logic [XLEN-1:0]     res_address_out;
    logic [4:0]          res_reg_index;
    logic                res_reg_write;
    logic [XLEN-1:0]     res_write_value;
    logic [XLEN-1:0]     res_next_pc;
    logic [2:0]          res_inst_len;

    rlstd_decode #(.XLEN(XLEN)) u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_command        (s_axis_tuser[0]),
        .i_trap_inst      (s_axis_tdata[31:0]),
        .i_fetched_inst   (s_axis_tdata[63:32]),
        .i_fetch_fault    (s_axis_tdata[64]),
        .i_fault_pc       (s_axis_tdata[128:65]),
        .i_access_address (s_axis_tdata[192:129]),
        .i_load_data      (s_axis_tdata[256:193]),
        .i_access_error   (s_axis_tdata[257]),
        .o_valid          (s1_valid),
        .i_ready          (s1_ready),
        .o_ctl            (s1_ctl),
        .o_pc             (s1_pc),
        .o_addr           (s1_addr),
        .o_data           (s1_data)
    );

    rlstd_extend #(.XLEN(XLEN)) u_extend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s1_valid),
        .o_ready   (s1_ready),
        .i_ctl     (s1_ctl),
        .i_pc      (s1_pc),
        .i_addr    (s1_addr),
        .i_data    (s1_data),
        .o_valid   (s2_valid),
        .i_ready   (s2_ready),
        .o_ctl     (s2_ctl),
        .o_pc      (s2_pc),
        .o_pc_next (s2_pc_next),
        .o_addr    (s2_addr),
        .o_ext     (s2_ext)
    );

    rlstd_result #(.XLEN(XLEN)) u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .o_ready       (s2_ready),
        .i_ctl         (s2_ctl),
        .i_pc          (s2_pc),
        .i_pc_next     (s2_pc_next),
        .i_addr        (s2_addr),
        .i_ext         (s2_ext),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_status      (res_status),
        .o_access_len  (res_access_len),
        .o_address_out (res_address_out),
        .o_reg_index   (res_reg_index),
        .o_reg_write   (res_reg_write),
        .o_write_value (res_write_value),
        .o_next_pc     (res_next_pc),
        .o_inst_len    (res_inst_len)
    );

    assign m_axis_tdata = {3'b000,
                           res_inst_len,
                           64'(res_next_pc),
                           64'(res_write_value),
                           res_reg_write,
                           res_reg_index,
                           64'(res_address_out),
                           res_access_len};
    assign m_axis_tuser = res_status;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output request present after reset");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output side is free");

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[73]) |-> (m_axis_tuser == rlstd_pkg::ST_OK))
        else $error("register write on a failed request");

    a_undecoded_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == rlstd_pkg::ST_FETCH_FAULT ||
                           m_axis_tuser == rlstd_pkg::ST_UNSUPPORTED))
        |-> (m_axis_tdata[3:0] == rlstd_pkg::LEN_NONE && m_axis_tdata[72:68] == 5'd0))
        else $error("undecoded request carries access fields");

endmodule
